// ===== hw/rtl/srm_pkg.sv =====
// Shared constants for the share ReLU / max-pool core.
// Depends on nothing; taken in by the channel interfaces and the core.
`default_nettype none

package srm_pkg;

  // Width of the share, mask, result and configuration data fields on the ports
  localparam int DATA_W = 32;

  // Default datapath width
  localparam int WIDTH_DEFAULT = 32;

  // Number of share pairs in one request
  localparam int PAIRS = 4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_MODE = 1'b1;

  // Register values after reset
  localparam logic [DATA_W-1:0] MODULUS_RESET   = DATA_W'(2);
  localparam logic              POOL_MODE_RESET = 1'b0;

endpackage

`default_nettype wire

// ===== hw/rtl/srm_if.sv =====
// Valid/ready channels of the share ReLU / max-pool core: item in,
// result out and configuration write. Depends on srm_pkg.
`default_nettype none

interface srm_item_if;
  import srm_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] client_share_0;
  logic [DATA_W-1:0] client_share_1;
  logic [DATA_W-1:0] client_share_2;
  logic [DATA_W-1:0] client_share_3;
  logic [DATA_W-1:0] server_share_0;
  logic [DATA_W-1:0] server_share_1;
  logic [DATA_W-1:0] server_share_2;
  logic [DATA_W-1:0] server_share_3;
  logic [DATA_W-1:0] output_mask;

  modport source (
    output valid, client_share_0, client_share_1, client_share_2, client_share_3,
    output server_share_0, server_share_1, server_share_2, server_share_3,
    output output_mask,
    input  ready
  );
  modport sink (
    input  valid, client_share_0, client_share_1, client_share_2, client_share_3,
    input  server_share_0, server_share_1, server_share_2, server_share_3,
    input  output_mask,
    output ready
  );
endinterface

interface srm_result_if;
  import srm_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] masked_result;

  modport source (output valid, masked_result, input ready);
  modport sink   (input valid, masked_result, output ready);
endinterface

interface srm_cfg_if;
  import srm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/share_relu_maxpool_modular_core.sv =====
// Share ReLU / 2x2 max-pool core: recombines additive shares mod p,
// takes the maximum with floor(p/2) and re-masks. Depends on srm_pkg, srm_if.
//
// Takes one request per clock cycle while the result sink keeps up and
// returns one result for each: the request is captured in an input register,
// and a single combinational pass (four share additions mod p, a max tree
// with floor(p/2), one masking addition mod p) feeds the result register.
// The input register keeps taking requests while a result waits at the
// output, so a stalled sink holds at most two requests in flight. Every
// addition mod p does one conditional subtraction only, so shares and
// mask are expected to be below p. Configuration writes are always taken
// and must only be issued with no request in flight.
`default_nettype none

module share_relu_maxpool_modular_core #(
  parameter int WIDTH = srm_pkg::WIDTH_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  srm_item_if.sink          item,
  srm_result_if.source      result,
  srm_cfg_if.sink           cfg
);
  import srm_pkg::*;

  localparam int EXT_W = (WIDTH > DATA_W) ? WIDTH : DATA_W;

  // Port field to datapath width: zero-extend or keep the low bits
  function automatic logic [WIDTH-1:0] to_dp(input logic [DATA_W-1:0] x);
    logic [EXT_W-1:0] e;
    e = EXT_W'(x);
    return e[WIDTH-1:0];
  endfunction

  // Datapath value back to port width
  function automatic logic [DATA_W-1:0] to_port(input logic [WIDTH-1:0] y);
    logic [EXT_W-1:0] e;
    e = EXT_W'(y);
    return e[DATA_W-1:0];
  endfunction

  // Addition mod p with a single conditional subtraction
  function automatic logic [WIDTH-1:0] mod_add(input logic [WIDTH-1:0] a,
                                               input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] p);
    logic [WIDTH:0]   s;
    logic [WIDTH-1:0] low;
    s   = {1'b0, a} + {1'b0, b};
    low = s[WIDTH-1:0];
    if (s[WIDTH] || (low >= p)) begin
      low = low - p;
    end
    return low;
  endfunction

  function automatic logic [WIDTH-1:0] umax(input logic [WIDTH-1:0] a,
                                            input logic [WIDTH-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // Configuration registers
  logic [DATA_W-1:0] modulus;
  logic              pool_mode;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus   <= MODULUS_RESET;
      pool_mode <= POOL_MODE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_MODULUS:   modulus   <= cfg.data;
        REG_POOL_MODE: pool_mode <= cfg.data[0];
        default:       ;
      endcase
    end
  end

  // Input register
  logic              in_vld;
  logic [DATA_W-1:0] in_cs [PAIRS];
  logic [DATA_W-1:0] in_ss [PAIRS];
  logic [DATA_W-1:0] in_mask;

  // Result register
  logic              res_vld;
  logic [DATA_W-1:0] res_data;

  logic adv;
  logic take;

  // Move the held request on when the result register is free or draining
  assign adv        = in_vld && (!res_vld || result.ready);
  assign item.ready = !in_vld || adv;
  assign take       = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (take) begin
      in_vld <= 1'b1;
    end else if (adv) begin
      in_vld <= 1'b0;
    end
  end

  // Capture request payload
  always_ff @(posedge clk) begin
    if (take) begin
      in_cs[0] <= item.client_share_0;
      in_cs[1] <= item.client_share_1;
      in_cs[2] <= item.client_share_2;
      in_cs[3] <= item.client_share_3;
      in_ss[0] <= item.server_share_0;
      in_ss[1] <= item.server_share_1;
      in_ss[2] <= item.server_share_2;
      in_ss[3] <= item.server_share_3;
      in_mask  <= item.output_mask;
    end
  end

  // Recombine, take the maximum with floor(p/2), re-mask
  logic [WIDTH-1:0] p;
  logic [WIDTH-1:0] half;
  logic [WIDTH-1:0] val [PAIRS];
  logic [WIDTH-1:0] max01;
  logic [WIDTH-1:0] max23;
  logic [WIDTH-1:0] cand;
  logic [WIDTH-1:0] best;
  logic [WIDTH-1:0] masked;

  assign p    = to_dp(modulus);
  assign half = p >> 1;

  always_comb begin
    for (int i = 0; i < PAIRS; i++) begin
      val[i] = mod_add(to_dp(in_cs[i]), to_dp(in_ss[i]), p);
    end
  end

  assign max01  = umax(val[0], val[1]);
  assign max23  = umax(val[2], val[3]);
  assign cand   = pool_mode ? umax(max01, max23) : val[0];
  assign best   = umax(cand, half);
  assign masked = mod_add(best, to_dp(in_mask), p);

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (adv) begin
      res_vld <= 1'b1;
    end else if (result.ready) begin
      res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_data <= to_port(masked);
    end
  end

  assign result.valid         = res_vld;
  assign result.masked_result = res_data;

  // Checks
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!in_vld && !res_vld))
    else $error("pipeline not empty after reset");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_vld && res_vld && !result.ready) |-> !item.ready)
    else $error("request taken while both stages are stalled");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    $rose(res_vld) |-> $past(in_vld))
    else $error("result appeared without a held request");

  a_hold_request: assert property (@(posedge clk) disable iff (rst)
    (in_vld && !adv) |=> in_vld)
    else $error("held request lost before it advanced");

endmodule

`default_nettype wire

// ===== dv/tb_share_relu_maxpool_modular_core.sv =====
// Self-checking testbench for share_relu_maxpool_modular_core: random and directed
// share requests, each checked against an in-bench prediction of the masked maximum.
// Depends on srm_pkg, srm_if and the core RTL.
`default_nettype none

module tb_share_relu_maxpool_modular_core;
  timeunit 1ns;
  timeprecision 1ps;

  import srm_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [1:0] {
    OP_ITEM,
    OP_CFG,
    OP_DRAIN
  } script_op_e;

  typedef struct {
    script_op_e                    kind;
    logic [PAIRS-1:0][DATA_W-1:0] client;
    logic [PAIRS-1:0][DATA_W-1:0] server;
    logic [DATA_W-1:0]            mask;
    logic [CFG_IDX_W-1:0]         reg_idx;
    logic [DATA_W-1:0]            reg_val;
  } script_entry_t;

  logic clk;
  logic rst;

  srm_item_if   item_ch ();
  srm_result_if res_ch ();
  srm_cfg_if    cfg_ch ();

  share_relu_maxpool_modular_core u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // Requests, register writes and pauses, consumed in order by the driver
  script_entry_t     share_script [$];
  // Masked maxima still owed by the core, oldest first
  logic [DATA_W-1:0] masked_expected [$];

  // Register copy used for prediction
  logic [DATA_W-1:0] modulus_cfg = MODULUS_RESET;
  logic              pool_cfg    = POOL_MODE_RESET;

  int in_flight       = 0;
  int errors          = 0;
  int results_checked = 0;
  int quiet_cycles    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Addition mod p with a single conditional subtraction
  function automatic logic [DATA_W-1:0] add_mod_p(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                                   logic [DATA_W-1:0] p);
    logic [DATA_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum[DATA_W] || sum[DATA_W-1:0] >= p) return sum[DATA_W-1:0] - p;
    return sum[DATA_W-1:0];
  endfunction

  // Recombine the used pairs, take the maximum with floor(p/2), re-mask
  function automatic logic [DATA_W-1:0] masked_max(script_entry_t req, logic [DATA_W-1:0] p,
                                                    logic pool);
    logic [DATA_W-1:0] best;
    logic [DATA_W-1:0] val;
    int                used;
    best = p >> 1;
    used = pool ? PAIRS : 1;
    for (int k = 0; k < used; k++) begin
      val = add_mod_p(req.client[k], req.server[k], p);
      if (val > best) best = val;
    end
    return add_mod_p(best, req.mask, p);
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 93) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Share value biased towards the edges of the modulus
  function automatic logic [DATA_W-1:0] pick_share(logic [DATA_W-1:0] p);
    case ($urandom_range(0, 15))
      0:       return $urandom;
      1:       return '0;
      2:       return (p == 0) ? '1 : p - 1;
      3:       return p >> 1;
      4:       return (p >> 1) + 1;
      default: return (p == 0) ? $urandom : $urandom % p;
    endcase
  endfunction

  task automatic add_item(input logic [PAIRS-1:0][DATA_W-1:0] c,
                          input logic [PAIRS-1:0][DATA_W-1:0] s,
                          input logic [DATA_W-1:0] m);
    script_entry_t e;
    e.kind    = OP_ITEM;
    e.client  = c;
    e.server  = s;
    e.mask    = m;
    e.reg_idx = '0;
    e.reg_val = '0;
    share_script.push_back(e);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    script_entry_t e;
    e.kind    = OP_CFG;
    e.client  = '0;
    e.server  = '0;
    e.mask    = '0;
    e.reg_idx = idx;
    e.reg_val = val;
    share_script.push_back(e);
  endtask

  task automatic add_drain();
    script_entry_t e;
    e.kind    = OP_DRAIN;
    e.client  = '0;
    e.server  = '0;
    e.mask    = '0;
    e.reg_idx = '0;
    e.reg_val = '0;
    share_script.push_back(e);
  endtask

  // Driver: present the head of the script, advance on each accepted request or write
  always @(posedge clk) begin : drv
    logic item_fire;
    logic cfg_fire;
    logic want_item;
    logic want_cfg;
    int   send_gap;
    int   tx_calm;
    item_fire = item_ch.valid && item_ch.ready;
    cfg_fire  = cfg_ch.valid && cfg_ch.ready;
    want_item = 1'b0;
    want_cfg  = 1'b0;
    if (rst) begin
      item_ch.valid <= 1'b0;
      cfg_ch.valid  <= 1'b0;
      send_gap = 0;
      tx_calm  = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) in_flight--;
      if (item_fire) begin
        masked_expected.push_back(masked_max(share_script[0], modulus_cfg, pool_cfg));
        void'(share_script.pop_front());
        in_flight++;
        if (tx_calm > 0) begin
          tx_calm--;
          send_gap = 0;
        end else begin
          send_gap = idle_len();
          if ($urandom_range(0, 39) == 0) tx_calm = $urandom_range(30, 150);
        end
      end
      if (cfg_fire) begin
        if (cfg_ch.index == REG_MODULUS) modulus_cfg = cfg_ch.data;
        else pool_cfg = cfg_ch.data[0];
        void'(share_script.pop_front());
      end
      // Hold off during a gap; writes and pauses wait for every result to come back
      if (send_gap > 0) begin
        send_gap--;
      end else if (share_script.size() > 0) begin
        case (share_script[0].kind)
          OP_ITEM:  want_item = 1'b1;
          OP_CFG:   want_cfg = (in_flight == 0);
          OP_DRAIN: if (in_flight == 0) void'(share_script.pop_front());
          default:  ;
        endcase
      end
      item_ch.valid <= want_item;
      if (want_item) begin
        item_ch.client_share_0 <= share_script[0].client[0];
        item_ch.client_share_1 <= share_script[0].client[1];
        item_ch.client_share_2 <= share_script[0].client[2];
        item_ch.client_share_3 <= share_script[0].client[3];
        item_ch.server_share_0 <= share_script[0].server[0];
        item_ch.server_share_1 <= share_script[0].server[1];
        item_ch.server_share_2 <= share_script[0].server[2];
        item_ch.server_share_3 <= share_script[0].server[3];
        item_ch.output_mask    <= share_script[0].mask;
      end
      cfg_ch.valid <= want_cfg;
      if (want_cfg) begin
        cfg_ch.index <= share_script[0].reg_idx;
        cfg_ch.data  <= share_script[0].reg_val;
      end
    end
  end

  // Monitor: check each result against the oldest prediction, drive ready
  always @(posedge clk) begin : mon
    logic [DATA_W-1:0] want;
    int                rx_hold;
    int                rx_calm;
    bit                long_hold_done;
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_hold        = 0;
      rx_calm        = 0;
      long_hold_done = 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (masked_expected.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("result %h with no request outstanding", res_ch.masked_result);
        end else begin
          want = masked_expected.pop_front();
          if (res_ch.masked_result !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("masked_result mismatch: expected %h, got %h", want,
                       res_ch.masked_result);
          end
        end
        results_checked++;
      end
      // One long back-pressure stretch so the core fills and stalls its input
      if (!long_hold_done && results_checked >= 300) begin
        long_hold_done = 1'b1;
        rx_hold        = 240;
      end
      if (rx_calm > 0) rx_calm--;
      else if ($urandom_range(0, 59) == 0) rx_calm = $urandom_range(30, 150);
      if (rx_hold == 0 && rx_calm == 0 && $urandom_range(0, 2) == 0) rx_hold = idle_len();
      if (rx_hold > 0) begin
        rx_hold--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("tb_share_relu_maxpool_modular_core: errors");
        $finish;
      end
    end
  end

  initial begin
    logic [DATA_W-1:0]            p;
    logic [DATA_W-1:0]            pm1;
    logic [DATA_W-1:0]            half;
    logic [PAIRS-1:0][DATA_W-1:0] c;
    logic [PAIRS-1:0][DATA_W-1:0] s;
    logic                         pool;
    int                           count;

    // Known values on every input from time zero
    clk                    = 1'b0;
    rst                    = 1'b1;
    item_ch.valid          = 1'b0;
    item_ch.client_share_0 = '0;
    item_ch.client_share_1 = '0;
    item_ch.client_share_2 = '0;
    item_ch.client_share_3 = '0;
    item_ch.server_share_0 = '0;
    item_ch.server_share_1 = '0;
    item_ch.server_share_2 = '0;
    item_ch.server_share_3 = '0;
    item_ch.output_mask    = '0;
    res_ch.ready           = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = '0;
    cfg_ch.data            = '0;

    // Reset settings: p = 2, ReLU on pair 0
    add_item('0, '0, '0);
    add_item({4{32'd1}}, {4{32'd1}}, 32'd1);
    add_item({32'd0, 32'd0, 32'd0, 32'd1}, '0, 32'd1);
    add_item({4{32'hFFFF_FFFF}}, {4{32'hFFFF_FFFF}}, 32'hFFFF_FFFF);

    // Largest 32-bit prime, pool mode
    p    = 32'hFFFF_FFFB;
    pm1  = p - 1;
    half = p >> 1;
    add_cfg(REG_MODULUS, p);
    add_cfg(REG_POOL_MODE, 32'd1);
    add_item('0, '0, '0);
    // both shares at p-1: the sum carries out of the datapath
    add_item({4{pm1}}, {4{pm1}}, pm1);
    for (int k = 0; k < PAIRS; k++) begin
      c    = '0;
      s    = '0;
      c[k] = pm1;
      add_item(c, s, 32'd5);
    end
    add_item({32'd4, 32'd3, 32'd2, 32'd1}, {32'd1, 32'd2, 32'd3, 32'd4}, pm1);
    // shares not below p: single subtraction only
    add_item({4{32'hFFFF_FFFF}}, {4{32'hFFFF_FFFF}}, 32'hFFFF_FFFF);
    add_item({half, 32'd0, 32'd1, 32'd0}, {32'd0, half + 1, half, half}, half);

    // ReLU with all-ones modulus: pairs 1..3 must not matter
    add_cfg(REG_MODULUS, 32'hFFFF_FFFF);
    add_cfg(REG_POOL_MODE, 32'd0);
    add_item({{3{32'hFFFF_FFFE}}, 32'd1}, {{3{32'hFFFF_FFFE}}, 32'd2}, 32'd7);
    add_item({{3{32'd0}}, 32'hFFFF_FFFE}, '0, 32'hFFFF_FFFE);
    add_item({{3{32'h8000_0000}}, 32'h7FFF_FFFF}, {32'd0, {3{32'h1234_5678}}},
             32'h8000_0000);

    // Modulus zero and one
    add_cfg(REG_MODULUS, 32'd0);
    add_cfg(REG_POOL_MODE, 32'd1);
    add_item({4{32'hFFFF_FFFF}}, {32'd1, 32'd2, 32'd3, 32'd4}, 32'hFFFF_FFF0);
    add_item({32'h1, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF}, '0, 32'd3);
    add_cfg(REG_MODULUS, 32'd1);
    add_cfg(REG_POOL_MODE, 32'd0);
    add_item('0, '0, '0);
    add_item({4{32'd1}}, {4{32'd1}}, 32'd1);

    // Random phases over a spread of moduli, both modes
    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0:       p = 32'hFFFF_FFFF;
        1:       p = 32'd2;
        2:       p = 32'hFFFF_FFFB;
        3:       p = 32'd3;
        4:       p = 32'h8000_0000;
        5:       p = 32'h7FFF_FFFF;
        6:       p = 32'd65521;
        7:       p = 32'd251;
        8:       p = 32'hFFFF_FFFF;
        9:       p = 32'd1;
        default: p = $urandom_range(2, 32'hFFFF_FFFF);
      endcase
      pool = (ph % 3 != 0);
      add_cfg(REG_MODULUS, p);
      add_cfg(REG_POOL_MODE, {31'd0, pool});
      count = (p < 4) ? 40 : 120;
      for (int n = 0; n < count; n++) begin
        for (int k = 0; k < PAIRS; k++) begin
          c[k] = pick_share(p);
          s[k] = pick_share(p);
        end
        add_item(c, s, pick_share(p));
        // pause the sender now and then until all results are back
        if (n == count / 2 && ph % 4 == 1) add_drain();
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Wait for the script to run out and every result to arrive
    while (share_script.size() != 0 || masked_expected.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);

    if (errors == 0 && masked_expected.size() == 0) begin
      $display("tb_share_relu_maxpool_modular_core: clean");
    end else begin
      $display("tb_share_relu_maxpool_modular_core: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
